FILE: sv/clmsq_pkg.sv
// Shared types and constants for the clamped local Mach squared core.
// No dependencies; the core and clmsq_cfg import this package.
`timescale 1ns / 1ps
`default_nettype none

package clmsq_pkg;

  localparam int unsigned SETTLE_W = 7;
  localparam logic [SETTLE_W-1:0] CFG_SETTLE = 7'd80;

  localparam logic [18:0] GAMMA_ONE = 19'd65536;

  localparam logic [18:0] GAMMA_RST      = 19'd91750;
  localparam logic [19:0] FAR_MACH_RST   = 20'd52429;
  localparam logic [31:0] FAR_VX_RST     = 32'd65536;
  localparam logic [31:0] FAR_VY_RST     = 32'd0;
  localparam logic [31:0] FAR_VZ_RST     = 32'd0;
  localparam logic [30:0] FAR_SOUND_RST  = 31'd22282240;
  localparam logic [19:0] LIMIT_RST      = 20'd196608;

  typedef enum logic [2:0] {
    REG_GAMMA     = 3'd0,
    REG_FAR_MACH  = 3'd1,
    REG_FAR_VX    = 3'd2,
    REG_FAR_VY    = 3'd3,
    REG_FAR_VZ    = 3'd4,
    REG_FAR_SOUND = 3'd5,
    REG_LIMIT     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [18:0] gm1;
    logic [39:0] msq;
    logic [58:0] p;
    logic [47:0] vf2;
    logic [61:0] a2;
    logic [47:0] vmax;
    logic        err;
  } derived_t;

endpackage

`default_nettype wire

FILE: sv/clamped_local_mach_squared_core.sv
// Clamped local Mach number squared core: one velocity word in, one result word out.
// Velocity words enter on vel_valid/vel_ready; results leave on res_valid/res_ready.
// Configuration is to be written over the APB-style port only while the core is idle;
// the user must keep to this, since the core itself does not enforce it.
// Throughput is one word per cycle while the pipeline neither stalls nor is busy.
// The depth is set by the pipelined dividers: 65 stages for the sound-speed factor,
// 33 for Mach squared and 64 for the two slope terms, plus the multipliers and registers.
// After reset and after every register write, vel_ready stays low until the CFG_SETTLE
// counter runs out; meanwhile the clamp limit and per-configuration terms are recomputed.
// The result register holds a word until res_ready takes it; meanwhile the pipeline
// keeps accepting words until its last stage holds one too, then it stalls as a whole.
// Reset clears all valid bits and restores the register reset values.
// Depends on clmsq_pkg, clmsq_cfg, clmsq_sumsq, clmsq_mul and clmsq_div.
`timescale 1ns / 1ps
`default_nettype none

module clamped_local_mach_squared_core #(
  parameter int unsigned DIMENSIONS = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               vel_valid,
  output logic               vel_ready,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] vel_z,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [47:0]        speed_sq,
  output logic [47:0]        sound_sq,
  output logic [31:0]        mach_sq,
  output logic [62:0]        mach_sq_slope,
  output logic               was_clamped,
  output logic               div_error
);

  import clmsq_pkg::*;

  typedef struct packed {
    logic [47:0] v2c;
    logic        clamped;
    logic        le;
  } sa_t;

  typedef struct packed {
    logic [47:0] v2c;
    logic        clamped;
  } sb_t;

  typedef struct packed {
    logic [47:0] v2c;
    logic        clamped;
    logic        err;
  } sc_t;

  typedef struct packed {
    logic [47:0]  v2c;
    logic         clamped;
    logic         err;
    logic [47:0]  sound;
    logic [112:0] den2;
  } sd_t;

  typedef struct packed {
    logic [31:0]  mach;
    logic [47:0]  v2c;
    logic         clamped;
    logic         err;
    logic [47:0]  sound;
    logic [112:0] den2;
  } se_t;

  typedef struct packed {
    logic [31:0] mach;
    logic [47:0] v2c;
    logic        clamped;
    logic        err;
    logic [47:0] sound;
  } sf_t;

  derived_t drv;
  logic     busy;
  logic     en, load, accept, last_valid;

  logic        v1_valid;
  logic [47:0] v2;

  logic        c_valid;
  logic [47:0] c_v2c;
  logic        c_clamped;

  logic        d_valid;
  sa_t         d_side;
  logic [47:0] d_diff;

  logic         t_valid;
  logic [106:0] t_prod;
  sa_t          t_side;

  logic         n_valid;
  logic [108:0] n_snum;
  sb_t          n_side;
  logic [108:0] base, tt;

  logic        s_valid;
  logic [63:0] s32;
  logic        s_dz;
  sb_t         s_side;
  sc_t         s_side_c;

  logic         p_valid;
  logic [125:0] prod;
  logic [112:0] den2;
  sc_t          p_side;

  logic  e_valid;
  sd_t   e_side;

  logic        m_valid;
  logic [31:0] mach;
  logic        m_dz;
  sd_t         m_side;
  se_t         m_side_e;

  logic        g_valid;
  logic [50:0] m1;
  se_t         g_side;

  logic        h_valid;
  logic [90:0] num2;
  se_t         h_side;
  sf_t         h_side_f;

  logic        t1_valid;
  logic [62:0] t1, t2;
  logic        t1_dz, t2_dz;
  sf_t         f_side;
  logic [63:0] slope_sum;

  assign pready = 1'b1;

  clmsq_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .use_z(DIMENSIONS != 2), .drv(drv), .busy(busy)
  );

  assign load      = !res_valid || res_ready;
  assign en        = load || !last_valid;
  assign vel_ready = en && !busy;
  assign accept    = vel_valid && vel_ready;

  clmsq_sumsq #(.WS(1)) u_v2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(accept),
    .x(vel_x), .y(vel_y), .z((DIMENSIONS == 2) ? 32'sd0 : vel_z),
    .side_in(1'b0), .out_valid(v1_valid), .sq(v2), .side_out()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      n_valid <= 1'b0;
      e_valid <= 1'b0;
    end else if (en) begin
      c_valid <= v1_valid;
      d_valid <= c_valid;
      n_valid <= t_valid;
      e_valid <= p_valid;
    end
  end

  assign base = 109'(drv.vf2) << 49;
  assign tt   = 109'(t_prod);

  always_ff @(posedge clk) begin
    if (en) begin
      c_clamped      <= v2 > drv.vmax;
      c_v2c          <= (v2 > drv.vmax) ? drv.vmax : v2;
      d_side.v2c     <= c_v2c;
      d_side.clamped <= c_clamped;
      d_side.le      <= c_v2c <= drv.vf2;
      d_diff         <= (c_v2c <= drv.vf2) ? (drv.vf2 - c_v2c) : (c_v2c - drv.vf2);
      if (t_side.le) begin
        n_snum <= base + tt;
      end else begin
        n_snum <= (tt >= base) ? '0 : (base - tt);
      end
      n_side.v2c     <= t_side.v2c;
      n_side.clamped <= t_side.clamped;
      e_side.v2c     <= p_side.v2c;
      e_side.clamped <= p_side.clamped;
      e_side.err     <= p_side.err;
      e_side.sound   <= (prod[125:96] != '0) ? '1 : prod[95:48];
      e_side.den2    <= den2;
    end
  end

  clmsq_mul #(.WA(59), .WB(48), .WS($bits(sa_t))) u_tprod (
    .clk(clk), .rst(rst), .en(en), .in_valid(d_valid),
    .a(drv.p), .b(d_diff), .side_in(d_side),
    .out_valid(t_valid), .p(t_prod), .side_out(t_side)
  );

  clmsq_div #(.WN(109), .WD(65), .WQ(64), .WS($bits(sb_t))) u_sdiv (
    .clk(clk), .rst(rst), .en(en), .in_valid(n_valid),
    .n(n_snum), .d({drv.vf2, 17'd0}), .side_in(n_side),
    .out_valid(s_valid), .q(s32), .dz(s_dz), .side_out(s_side)
  );

  assign s_side_c.v2c     = s_side.v2c;
  assign s_side_c.clamped = s_side.clamped;
  assign s_side_c.err     = s_dz;

  clmsq_mul #(.WA(62), .WB(64), .WS($bits(sc_t))) u_sound (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_valid),
    .a(drv.a2), .b(s32), .side_in(s_side_c),
    .out_valid(p_valid), .p(prod), .side_out(p_side)
  );

  clmsq_mul #(.WA(49), .WB(64), .WS(1)) u_den2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_valid),
    .a({drv.vf2, 1'b0}), .b(s32), .side_in(1'b0),
    .out_valid(), .p(den2), .side_out()
  );

  clmsq_div #(.WN(64), .WD(48), .WQ(32), .WS($bits(sd_t))) u_mdiv (
    .clk(clk), .rst(rst), .en(en), .in_valid(e_valid),
    .n({e_side.v2c, 16'd0}), .d(e_side.sound), .side_in(e_side),
    .out_valid(m_valid), .q(mach), .dz(m_dz), .side_out(m_side)
  );

  assign m_side_e.mach    = mach;
  assign m_side_e.v2c     = m_side.v2c;
  assign m_side_e.clamped = m_side.clamped;
  assign m_side_e.err     = m_side.err || m_dz;
  assign m_side_e.sound   = m_side.sound;
  assign m_side_e.den2    = m_side.den2;

  clmsq_mul #(.WA(32), .WB(19), .WS($bits(se_t))) u_m1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(m_valid),
    .a(mach), .b(drv.gm1), .side_in(m_side_e),
    .out_valid(g_valid), .p(m1), .side_out(g_side)
  );

  clmsq_mul #(.WA(51), .WB(40), .WS($bits(se_t))) u_m2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(g_valid),
    .a(m1), .b(drv.msq), .side_in(g_side),
    .out_valid(h_valid), .p(num2), .side_out(h_side)
  );

  assign h_side_f.mach    = h_side.mach;
  assign h_side_f.v2c     = h_side.v2c;
  assign h_side_f.clamped = h_side.clamped;
  assign h_side_f.err     = h_side.err;
  assign h_side_f.sound   = h_side.sound;

  clmsq_div #(.WN(80), .WD(48), .WQ(63), .WS($bits(sf_t))) u_t1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(h_valid),
    .n({h_side.mach, 48'd0}), .d(h_side.v2c), .side_in(h_side_f),
    .out_valid(t1_valid), .q(t1), .dz(t1_dz), .side_out(f_side)
  );

  clmsq_div #(.WN(123), .WD(113), .WQ(63), .WS(1)) u_t2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(h_valid),
    .n({num2, 32'd0}), .d(h_side.den2), .side_in(1'b0),
    .out_valid(), .q(t2), .dz(t2_dz), .side_out()
  );

  assign last_valid = t1_valid;
  assign slope_sum  = 64'(t1) + 64'(t2);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      speed_sq      <= f_side.v2c;
      sound_sq      <= f_side.sound;
      mach_sq       <= f_side.mach;
      mach_sq_slope <= slope_sum[63] ? '1 : slope_sum[62:0];
      was_clamped   <= f_side.clamped;
      div_error     <= f_side.err || t1_dz || t2_dz || drv.err;
    end
  end

endmodule

`default_nettype wire

FILE: sv/clmsq_mul.sv
// Pipelined unsigned multiplier, one 32 by 32 partial product per stage.
// Carries a valid bit and a sideband word; uses no package.
`timescale 1ns / 1ps
`default_nettype none

module clmsq_mul #(
  parameter int unsigned WA = 32,
  parameter int unsigned WB = 32,
  parameter int unsigned WS = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  input  logic [WS-1:0]    side_in,
  output logic             out_valid,
  output logic [WA+WB-1:0] p,
  output logic [WS-1:0]    side_out
);

  localparam int unsigned NA  = (WA + 31) / 32;
  localparam int unsigned NB  = (WB + 31) / 32;
  localparam int unsigned NS  = NA * NB;
  localparam int unsigned WAP = NA * 32;
  localparam int unsigned WBP = NB * 32;
  localparam int unsigned WP  = WAP + WBP;

  logic            vld   [NS];
  logic [WAP-1:0]  a_r   [NS];
  logic [WBP-1:0]  b_r   [NS];
  logic [WS-1:0]   s_r   [NS];
  logic [WP-1:0]   acc_r [NS];

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_st
      localparam int unsigned I = k % NA;
      localparam int unsigned J = k / NA;
      logic           v_prev;
      logic [WAP-1:0] a_prev;
      logic [WBP-1:0] b_prev;
      logic [WS-1:0]  s_prev;
      logic [WP-1:0]  acc_prev;
      logic [63:0]    pp;

      if (k == 0) begin : g_first
        assign v_prev   = in_valid;
        assign a_prev   = WAP'(a);
        assign b_prev   = WBP'(b);
        assign s_prev   = side_in;
        assign acc_prev = '0;
      end else begin : g_next
        assign v_prev   = vld[k-1];
        assign a_prev   = a_r[k-1];
        assign b_prev   = b_r[k-1];
        assign s_prev   = s_r[k-1];
        assign acc_prev = acc_r[k-1];
      end

      assign pp = 64'(a_prev[32*I +: 32]) * 64'(b_prev[32*J +: 32]);

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (en) begin
          vld[k] <= v_prev;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          a_r[k]   <= a_prev;
          b_r[k]   <= b_prev;
          s_r[k]   <= s_prev;
          acc_r[k] <= acc_prev + (WP'(pp) << (32 * (I + J)));
        end
      end
    end
  endgenerate

  assign out_valid = vld[NS-1];
  assign p         = acc_r[NS-1][WA+WB-1:0];
  assign side_out  = s_r[NS-1];

endmodule

`default_nettype wire

FILE: sv/clmsq_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating.
// A first stage detects overflow and a zero divisor; uses no package.
`timescale 1ns / 1ps
`default_nettype none

module clmsq_div #(
  parameter int unsigned WN = 64,
  parameter int unsigned WD = 32,
  parameter int unsigned WQ = 32,
  parameter int unsigned WS = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [WN-1:0] n,
  input  logic [WD-1:0] d,
  input  logic [WS-1:0] side_in,
  output logic          out_valid,
  output logic [WQ-1:0] q,
  output logic          dz,
  output logic [WS-1:0] side_out
);

  localparam int unsigned WH = WN - WQ;
  localparam int unsigned WC = (WH > WD) ? WH : WD;

  logic          vld   [WQ+1];
  logic [WD-1:0] rem_r [WQ+1];
  logic [WQ-1:0] nl_r  [WQ+1];
  logic [WQ-1:0] q_r   [WQ+1];
  logic [WD-1:0] d_r   [WQ+1];
  logic          sat_r [WQ+1];
  logic          dz_r  [WQ+1];
  logic [WS-1:0] s_r   [WQ+1];

  logic [WH-1:0] hi;
  logic          ovf;

  assign hi  = n[WN-1:WQ];
  assign ovf = WC'(hi) >= WC'(d);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= ovf ? '0 : WD'(hi);
      nl_r[0]  <= n[WQ-1:0];
      q_r[0]   <= '0;
      d_r[0]   <= d;
      sat_r[0] <= ovf;
      dz_r[0]  <= (d == '0);
      s_r[0]   <= side_in;
    end
  end

  genvar k;
  generate
    for (k = 1; k <= WQ; k++) begin : g_st
      logic [WD:0] r_ext;
      logic [WD:0] r_sub;
      logic        ge;

      assign r_ext = {rem_r[k-1], nl_r[k-1][WQ-1]};
      assign ge    = r_ext >= {1'b0, d_r[k-1]};
      assign r_sub = r_ext - {1'b0, d_r[k-1]};

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (en) begin
          vld[k] <= vld[k-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? r_sub[WD-1:0] : r_ext[WD-1:0];
          nl_r[k]  <= nl_r[k-1] << 1;
          q_r[k]   <= (q_r[k-1] << 1) | WQ'(ge);
          d_r[k]   <= d_r[k-1];
          sat_r[k] <= sat_r[k-1];
          dz_r[k]  <= dz_r[k-1];
          s_r[k]   <= s_r[k-1];
        end
      end
    end
  endgenerate

  assign out_valid = vld[WQ];
  assign q         = sat_r[WQ] ? '1 : q_r[WQ];
  assign dz        = dz_r[WQ];
  assign side_out  = s_r[WQ];

endmodule

`default_nettype wire

FILE: sv/clmsq_sumsq.sv
// Two-stage sum of squares of three signed Q16.16 components, result Q32.16.
// Carries a valid bit and a sideband word; uses no package.
`timescale 1ns / 1ps
`default_nettype none

module clmsq_sumsq #(
  parameter int unsigned WS = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] x,
  input  logic signed [31:0] y,
  input  logic signed [31:0] z,
  input  logic [WS-1:0]      side_in,
  output logic               out_valid,
  output logic [47:0]        sq,
  output logic [WS-1:0]      side_out
);

  logic [31:0] mx, my, mz;
  logic [63:0] sa, sb, sc;
  logic [63:0] tot;
  logic        v1;
  logic [WS-1:0] s1;

  assign mx  = x[31] ? (~x + 32'd1) : x;
  assign my  = y[31] ? (~y + 32'd1) : y;
  assign mz  = z[31] ? (~z + 32'd1) : z;
  assign tot = sa + sb + sc;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa       <= 64'(mx) * 64'(mx);
      sb       <= 64'(my) * 64'(my);
      sc       <= 64'(mz) * 64'(mz);
      s1       <= side_in;
      sq       <= tot[63:16];
      side_out <= s1;
    end
  end

endmodule

`default_nettype wire

FILE: sv/clmsq_cfg.sv
// Configuration registers, register port and the per-configuration terms.
// Depends on clmsq_pkg, clmsq_sumsq, clmsq_mul and clmsq_div.
`timescale 1ns / 1ps
`default_nettype none

module clmsq_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  input  logic                use_z,
  output clmsq_pkg::derived_t drv,
  output logic                busy
);

  import clmsq_pkg::*;

  logic [18:0] gamma_ratio;
  logic [19:0] far_mach;
  logic [31:0] far_vel_x, far_vel_y, far_vel_z;
  logic [30:0] far_sound_speed;
  logic [19:0] mach_sq_limit;

  logic [SETTLE_W-1:0] cnt;
  logic                wr;
  reg_idx_t            idx;

  logic [18:0]  gm1;
  logic [47:0]  vf2;
  logic [39:0]  msq;
  logic [61:0]  a2;
  logic [38:0]  gml;
  logic [58:0]  p;
  logic [67:0]  vl;
  logic [59:0]  nterm;
  logic [39:0]  dterm;
  logic [127:0] num;
  logic [79:0]  den;
  logic [47:0]  vmax;
  logic         verr;

  assign wr  = psel && penable && pwrite;
  assign idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_ratio     <= GAMMA_RST;
      far_mach        <= FAR_MACH_RST;
      far_vel_x       <= FAR_VX_RST;
      far_vel_y       <= FAR_VY_RST;
      far_vel_z       <= FAR_VZ_RST;
      far_sound_speed <= FAR_SOUND_RST;
      mach_sq_limit   <= LIMIT_RST;
    end else if (wr) begin
      unique case (idx)
        REG_GAMMA:     gamma_ratio     <= pwdata[18:0];
        REG_FAR_MACH:  far_mach        <= pwdata[19:0];
        REG_FAR_VX:    far_vel_x       <= pwdata;
        REG_FAR_VY:    far_vel_y       <= pwdata;
        REG_FAR_VZ:    far_vel_z       <= pwdata;
        REG_FAR_SOUND: far_sound_speed <= pwdata[30:0];
        REG_LIMIT:     mach_sq_limit   <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAMMA:     prdata = 32'(gamma_ratio);
      REG_FAR_MACH:  prdata = 32'(far_mach);
      REG_FAR_VX:    prdata = far_vel_x;
      REG_FAR_VY:    prdata = far_vel_y;
      REG_FAR_VZ:    prdata = far_vel_z;
      REG_FAR_SOUND: prdata = 32'(far_sound_speed);
      REG_LIMIT:     prdata = 32'(mach_sq_limit);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= CFG_SETTLE;
    end else if (wr) begin
      cnt <= CFG_SETTLE;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  assign busy = (cnt != '0);

  assign gm1 = (gamma_ratio > GAMMA_ONE) ? (gamma_ratio - GAMMA_ONE) : '0;

  clmsq_sumsq #(.WS(1)) u_vf2 (
    .clk(clk), .rst(rst), .en(1'b1), .in_valid(1'b0),
    .x(far_vel_x), .y(far_vel_y), .z(use_z ? far_vel_z : 32'd0),
    .side_in(1'b0), .out_valid(), .sq(vf2), .side_out()
  );

  clmsq_mul #(.WA(20), .WB(20), .WS(1)) u_msq (
    .clk(clk), .rst(rst), .en(1'b1), .in_valid(1'b0),
    .a(far_mach), .b(far_mach), .side_in(1'b0),
    .out_valid(), .p(msq), .side_out()
  );

  clmsq_mul #(.WA(31), .WB(31), .WS(1)) u_a2 (
    .clk(clk), .rst(rst), .en(1'b1), .in_valid(1'b0),
    .a(far_sound_speed), .b(far_sound_speed), .side_in(1'b0),
    .out_valid(), .p(a2), .side_out()
  );

  clmsq_mul #(.WA(19), .WB(20), .WS(1)) u_gml (
    .clk(clk), .rst(rst), .en(1'b1), .in_valid(1'b0),
    .a(gm1), .b(mach_sq_limit), .side_in(1'b0),
    .out_valid(), .p(gml), .side_out()
  );

  clmsq_mul #(.WA(19), .WB(40), .WS(1)) u_p (
    .clk(clk), .rst(rst), .en(1'b1), .in_valid(1'b0),
    .a(gm1), .b(msq), .side_in(1'b0),
    .out_valid(), .p(p), .side_out()
  );

  clmsq_mul #(.WA(48), .WB(20), .WS(1)) u_vl (
    .clk(clk), .rst(rst), .en(1'b1), .in_valid(1'b0),
    .a(vf2), .b(mach_sq_limit), .side_in(1'b0),
    .out_valid(), .p(vl), .side_out()
  );

  assign nterm = (60'd1 << 49) + 60'(p);
  assign dterm = (40'd1 << 33) + 40'(gml);

  clmsq_mul #(.WA(68), .WB(60), .WS(1)) u_num (
    .clk(clk), .rst(rst), .en(1'b1), .in_valid(1'b0),
    .a(vl), .b(nterm), .side_in(1'b0),
    .out_valid(), .p(num), .side_out()
  );

  clmsq_mul #(.WA(40), .WB(40), .WS(1)) u_den (
    .clk(clk), .rst(rst), .en(1'b1), .in_valid(1'b0),
    .a(msq), .b(dterm), .side_in(1'b0),
    .out_valid(), .p(den), .side_out()
  );

  clmsq_div #(.WN(128), .WD(80), .WQ(48), .WS(1)) u_vmax (
    .clk(clk), .rst(rst), .en(1'b1), .in_valid(1'b0),
    .n(num), .d(den), .side_in(1'b0),
    .out_valid(), .q(vmax), .dz(verr), .side_out()
  );

  assign drv.gm1  = gm1;
  assign drv.msq  = msq;
  assign drv.p    = p;
  assign drv.vf2  = vf2;
  assign drv.a2   = a2;
  assign drv.vmax = vmax;
  assign drv.err  = verr;

endmodule

`default_nettype wire
